### design/text_console_cursor_control_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text console cursor control block
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH

`ifndef ASSERT_OFF

`define TCC_ASSERT_NOW(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tcc: assertion failed");

`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcc: assertion failed");

`else

`define TCC_ASSERT_NOW(label, clk, rst, expr)

`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/tcc_pkg.sv
// ---------------------------------------------------------------------------
// Text console cursor control package
// Types, command codes, control characters and register indexes.
// ---------------------------------------------------------------------------
package tcc_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 128;

   localparam int COL_W      = 8;
   localparam int ROW_W      = 7;
   localparam int CHAR_W     = 7;
   localparam int CFG_W      = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int BURST_LEN  = 4;
   localparam int CNT_W      = 3;
   localparam int IDX_W      = 2;

   typedef enum logic [2:0] {
      CMD_INVERT      = 3'd0,
      CMD_GLYPH       = 3'd1,
      CMD_SCROLL_UP   = 3'd2,
      CMD_SCROLL_DOWN = 3'd3,
      CMD_CLEAR       = 3'd4
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SCREEN_PRESENT = 3'd0,
      REG_COLUMNS        = 3'd1,
      REG_ROWS           = 3'd2,
      REG_GLYPH_FIRST    = 3'd3,
      REG_GLYPH_LAST     = 3'd4
   } csr_index_type;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE   = 7'o10;
   localparam logic [CHAR_W-1:0] CH_LINE_FEED   = 7'o12;
   localparam logic [CHAR_W-1:0] CH_CURSOR_UP   = 7'o13;
   localparam logic [CHAR_W-1:0] CH_CURSOR_RT   = 7'o14;
   localparam logic [CHAR_W-1:0] CH_CR          = 7'o15;
   localparam logic [CHAR_W-1:0] CH_REVERSE_LF  = 7'o22;
   localparam logic [CHAR_W-1:0] CH_DELETE_LINE = 7'o30;
   localparam logic [CHAR_W-1:0] CH_CLEAR       = 7'o32;
   localparam logic [CHAR_W-1:0] CH_SPACE       = 7'd32;

   typedef struct packed {
      cmd_type           command;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [CHAR_W-1:0] glyph;
   } entry_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
   } cursor_type;

   typedef struct packed {
      logic [CFG_W-1:0]  columns;
      logic [7:0]        rows;
      logic [CHAR_W-1:0] glyph_first;
      logic [CHAR_W-1:0] glyph_last;
   } cfg_type;

   typedef struct packed {
      entry_type [BURST_LEN-1:0] entry;
      logic [CNT_W-1:0]          count;
   } burst_type;

endpackage

### design/tcc_decode.sv
// ---------------------------------------------------------------------------
// Character decoder
// Turns one character and the current cursor into a burst of two to four
// drawing commands and the next cursor position.
// ---------------------------------------------------------------------------
module tcc_decode (
   input  logic [tcc_pkg::CHAR_W-1:0] ch,
   input  tcc_pkg::cursor_type         cursor,
   input  tcc_pkg::cfg_type            cfg,
   output tcc_pkg::burst_type          burst,
   output tcc_pkg::cursor_type         next_cursor
);
   import tcc_pkg::*;

   logic [CFG_W-1:0] ncol;
   logic [7:0]       nrow;
   logic [CFG_W-1:0] col_inc;
   logic [7:0]       row_inc;
   logic             at_bottom;
   logic [ROW_W-1:0] row_last;
   logic             drawable;
   entry_type        mid0;
   entry_type        mid1;
   logic [1:0]       nmid;
   cursor_type       nxt;
   entry_type        inv_old;
   entry_type        inv_new;

   always_comb begin
      if (cfg.columns == '0) begin
         ncol = CFG_W'(1);
      end else if (cfg.columns > CFG_W'(MAX_COLUMNS)) begin
         ncol = CFG_W'(MAX_COLUMNS);
      end else begin
         ncol = cfg.columns;
      end
      if (cfg.rows == '0) begin
         nrow = 8'd1;
      end else if (cfg.rows > 8'(MAX_ROWS)) begin
         nrow = 8'(MAX_ROWS);
      end else begin
         nrow = cfg.rows;
      end
   end

   assign col_inc   = {1'b0, cursor.column} + CFG_W'(1);
   assign row_inc   = {1'b0, cursor.row} + 8'd1;
   assign at_bottom = (row_inc >= nrow);
   assign row_last  = ROW_W'(nrow - 8'd1);
   assign drawable  = (ch >= cfg.glyph_first) && (ch <= cfg.glyph_last);

   always_comb begin
      nxt  = cursor;
      mid0 = '0;
      mid1 = '0;
      nmid = 2'd0;
      unique case (ch)
         CH_BACKSPACE: begin
            if (cursor.column != '0) begin
               nxt.column = cursor.column - COL_W'(1);
            end
            mid0 = '{command: CMD_GLYPH, column: nxt.column, row: cursor.row,
                     glyph: CH_SPACE};
            nmid = 2'd1;
         end
         CH_CR: begin
            nxt.column = '0;
         end
         CH_LINE_FEED: begin
            if (at_bottom) begin
               nxt.row = row_last;
               mid0    = '{command: CMD_SCROLL_UP, column: '0, row: '0, glyph: '0};
               nmid    = 2'd1;
            end else begin
               nxt.row = row_inc[ROW_W-1:0];
            end
         end
         CH_CURSOR_UP: begin
            if (cursor.row != '0) begin
               nxt.row = cursor.row - ROW_W'(1);
            end
         end
         CH_CURSOR_RT: begin
            if (col_inc < ncol) begin
               nxt.column = col_inc[COL_W-1:0];
            end
         end
         CH_CLEAR: begin
            nxt  = '0;
            mid0 = '{command: CMD_CLEAR, column: '0, row: '0, glyph: '0};
            mid1 = '{command: CMD_INVERT, column: '0, row: '0, glyph: '0};
            nmid = 2'd2;
         end
         CH_REVERSE_LF: begin
            if (cursor.row != '0) begin
               nxt.row = cursor.row - ROW_W'(1);
            end else begin
               mid0 = '{command: CMD_SCROLL_DOWN, column: '0, row: '0, glyph: '0};
               nmid = 2'd1;
            end
         end
         CH_DELETE_LINE: begin
            mid0 = '{command: CMD_SCROLL_UP, column: '0, row: cursor.row, glyph: '0};
            nmid = 2'd1;
         end
         default: begin
            if (drawable) begin
               mid0 = '{command: CMD_GLYPH, column: cursor.column, row: cursor.row,
                        glyph: ch};
               nmid = 2'd1;
               if (col_inc >= ncol) begin
                  nxt.column = '0;
                  if (at_bottom) begin
                     nxt.row = row_last;
                     mid1    = '{command: CMD_SCROLL_UP, column: '0, row: '0,
                                 glyph: '0};
                     nmid    = 2'd2;
                  end else begin
                     nxt.row = row_inc[ROW_W-1:0];
                  end
               end else begin
                  nxt.column = col_inc[COL_W-1:0];
               end
            end
         end
      endcase
   end

   assign inv_old = '{command: CMD_INVERT, column: cursor.column, row: cursor.row,
                      glyph: '0};
   assign inv_new = '{command: CMD_INVERT, column: nxt.column, row: nxt.row,
                      glyph: '0};

   always_comb begin
      burst.entry    = '0;
      burst.entry[0] = inv_old;
      unique case (nmid)
         2'd0: begin
            burst.entry[1] = inv_new;
         end
         2'd1: begin
            burst.entry[1] = mid0;
            burst.entry[2] = inv_new;
         end
         2'd2: begin
            burst.entry[1] = mid0;
            burst.entry[2] = mid1;
            burst.entry[3] = inv_new;
         end
         default: begin
            burst.entry[1] = inv_new;
         end
      endcase
      burst.count = CNT_W'(nmid) + CNT_W'(2);
   end

   assign next_cursor = nxt;

endmodule

### design/tcc_seq.sv
// ---------------------------------------------------------------------------
// Command sequencer
// Holds one burst and hands its commands out one per cycle unless out_ready
// stalls, via the result register; next burst loads as the last one leaves.
// ---------------------------------------------------------------------------
module tcc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   output logic                load_ready,
   input  tcc_pkg::burst_type  burst,
   output logic                out_valid,
   input  logic                out_ready,
   output tcc_pkg::entry_type  out_entry,
   output logic                out_last
);
   import tcc_pkg::*;

   burst_type        burst_ff;
   burst_type        burst_in;
   logic             busy_ff;
   logic             busy_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   entry_type        out_entry_ff;
   entry_type        out_entry_in;
   logic             out_last_ff;
   logic             out_last_in;
   logic             send;
   logic             is_last;
   logic             load;

   assign is_last    = (({1'b0, idx_ff} + CNT_W'(1)) == burst_ff.count);
   assign send       = busy_ff && (!out_valid_ff || out_ready);
   assign load_ready = !busy_ff || (send && is_last);
   assign load       = load_valid && load_ready;

   always_comb begin
      burst_in     = burst_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_entry_in = out_entry_ff;
      out_last_in  = out_last_ff;
      if (send) begin
         out_valid_in = 1'b1;
         out_entry_in = burst_ff.entry[idx_ff];
         out_last_in  = is_last;
         idx_in       = idx_ff + IDX_W'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         burst_in = burst;
         busy_in  = 1'b1;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      burst_ff     <= burst_in;
      out_entry_ff <= out_entry_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_entry = out_entry_ff;
   assign out_last  = out_last_ff;

endmodule

### design/text_console_cursor_control.sv
// ---------------------------------------------------------------------------
// Text console cursor control
// Takes characters, tracks the cursor of a text screen and emits the drawing
// commands for each character.
// ---------------------------------------------------------------------------
// Each request carries one character; it produces two to four commands
// (invert old cursor cell, up to two actions, invert new cursor cell), the
// final one marked with rsp_tlast. Commands leave through the result register
// at one per cycle unless rsp_tready stalls them; the next character's burst
// loads in the cycle its predecessor's last command is sent. A request's
// first command passes the input register, the burst register and the result
// register. With screen_present at 0, requests are taken and dropped.
`include "text_console_cursor_control_assert.svh"

module text_console_cursor_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] character, [7] ignored
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] command, [10:3] cell_column,
                                    // [17:11] cell_row, [24:18] glyph_code
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_addr,
   input  logic [8:0]  csr_wdata
);
   import tcc_pkg::*;

   logic              screen_ff;
   logic              screen_in;
   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_char_ff;
   logic [7:0]        in_char_in;
   cursor_type        cursor_ff;
   cursor_type        cursor_in;
   burst_type         dec_burst;
   cursor_type        dec_cursor;
   logic              load_valid;
   logic              load_ready;
   logic              in_consume;
   entry_type         out_entry;

   always_comb begin
      screen_in = screen_ff;
      cfg_in    = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            REG_SCREEN_PRESENT: screen_in          = csr_wdata[0];
            REG_COLUMNS:        cfg_in.columns     = csr_wdata;
            REG_ROWS:           cfg_in.rows        = csr_wdata[7:0];
            REG_GLYPH_FIRST:    cfg_in.glyph_first = csr_wdata[CHAR_W-1:0];
            REG_GLYPH_LAST:     cfg_in.glyph_last  = csr_wdata[CHAR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign load_valid = in_valid_ff && screen_ff;
   assign in_consume = in_valid_ff && (!screen_ff || load_ready);
   assign req_tready = !in_valid_ff || in_consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (in_consume) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
      end
      cursor_in = cursor_ff;
      if (load_valid && load_ready) begin
         cursor_in = dec_cursor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff          <= 1'b0;
         cfg_ff.columns     <= 9'd80;
         cfg_ff.rows        <= 8'd25;
         cfg_ff.glyph_first <= 7'd32;
         cfg_ff.glyph_last  <= 7'd126;
         in_valid_ff        <= 1'b0;
         cursor_ff          <= '0;
      end else begin
         screen_ff   <= screen_in;
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
         cursor_ff   <= cursor_in;
      end
      in_char_ff <= in_char_in;
   end

   tcc_decode u_decode (
      .ch          (in_char_ff[CHAR_W-1:0]),
      .cursor      (cursor_ff),
      .cfg         (cfg_ff),
      .burst       (dec_burst),
      .next_cursor (dec_cursor)
   );

   tcc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_ready (load_ready),
      .burst      (dec_burst),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_entry  (out_entry),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, out_entry.glyph, out_entry.row, out_entry.column,
                       out_entry.command};

   `TCC_ASSERT_NOW(a_burst_count, clock, reset,
      !load_valid || (dec_burst.count >= 3'd2 && dec_burst.count <= 3'd4))
   `TCC_ASSERT_NEXT(a_cursor_hold, clock, reset,
      !(load_valid && load_ready), $stable(cursor_ff))

endmodule
